[rtl/swmm_pkg.sv]
// Package: shared constants, types and state codes for the sliding window min/max core.
`default_nettype none
package swmm_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_WINDOW  = 256;
  localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
  localparam int LEN_BITS    = 9;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  localparam len_t MAX_LEN = len_t'(MAX_WINDOW);

  typedef struct packed {
    sample_t win_max;
    sample_t win_min;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/swmm_scan.sv]
// Sample memory, fill tracking and sequential window scan.
`default_nettype none
module swmm_scan (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  swmm_pkg::sample_t sample,
  input  wire                     new_stream,
  input  wire  swmm_pkg::len_t    win_len,
  output logic                    res_valid,
  input  wire                     res_ready,
  output swmm_pkg::result_t       res
);
  import swmm_pkg::*;

  state_t  state, state_next;
  addr_t   write_position;
  len_t    fill_count;
  addr_t   ptr;
  addr_t   cnt;
  logic    rd_vld;
  sample_t rd_q;
  sample_t lo, hi;
  sample_t mem [MAX_WINDOW];

  logic    accept;
  logic    rd_en;
  addr_t   wp;
  len_t    fc;
  len_t    fc_next;
  logic    has_result;

  assign accept = in_valid && in_ready;
  assign wp     = new_stream ? '0 : write_position;
  assign fc     = new_stream ? '0 : fill_count;
  assign fc_next = (fc < MAX_LEN) ? fc + len_t'(1) : fc;
  assign has_result = (fc_next >= win_len);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && has_result) begin
          state_next = (win_len == len_t'(1)) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == '0 && !rd_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_SCAN: rd_en     = (cnt != '0);
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.win_min = lo;
  assign res.win_max = hi;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp] <= sample;
    end
    if (rd_en) begin
      rd_q <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      write_position <= '0;
      fill_count     <= '0;
      rd_vld         <= 1'b0;
      cnt            <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (accept) begin
        write_position <= wp + addr_t'(1);
        fill_count     <= fc_next;
        cnt            <= addr_t'(win_len - len_t'(1));
      end else if (rd_en) begin
        cnt <= cnt - addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo  <= sample;
      hi  <= sample;
      ptr <= wp - addr_t'(1);
    end else begin
      if (rd_en) begin
        ptr <= ptr - addr_t'(1);
      end
      if (rd_vld) begin
        if (rd_q < lo) lo <= rd_q;
        if (rd_q > hi) hi <= rd_q;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sliding_window_min_max_core.sv]
// Top level: window length register, scan unit and output register.
//
// channel   dir  tdata / data            tuser
// s_axis    in   [31:0] sample           [0] new_stream
// m_axis    out  [31:0] window_min,      -
//                [63:32] window_max
// cfg       in   [8:0] window_len (write enable cfg_we)
//
// A beat with no result is taken without a scan. A beat with a result starts a scan
// (none for window_len 1), paced by the single read port of the sample memory,
// read once per older sample in the window.
// Reset clears history and sets window_len to 1. A stalled output holds one result
// in the output register; the scan unit waits in its done state until it can load.
`default_nettype none
module sliding_window_min_max_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] sample
  input  wire         s_axis_tuser,   // [0] new_stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] window_min, [63:32] window_max
  input  wire         cfg_we,
  input  wire  [8:0]  cfg_wdata
);
  import swmm_pkg::*;

  len_t    window_len;
  len_t    len_eff;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= len_t'(1);
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_len == '0) begin
      len_eff = len_t'(1);
    end else if (window_len > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = window_len;
    end
  end

  swmm_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .sample     (sample_t'(s_axis_tdata)),
    .new_stream (s_axis_tuser),
    .win_len    (len_eff),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {out_q.win_max, out_q.win_min};

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len_eff != '0 && len_eff <= MAX_LEN)
    else $error("effective window length out of range");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> s_axis_tready)
    else $error("scan unit not idle after handing off a result");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.win_min <= res.win_max)
    else $error("window minimum above maximum");
`endif

endmodule
`default_nettype wire

[tb/sv/window_extrema_check.sv]
// Checker: predicts the window minimum and maximum for each input beat and compares results.
module window_extrema_check (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [31:0] s_axis_tdata,   // [31:0] sample
  input  wire        s_axis_tuser,   // [0] new_stream
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [63:0] m_axis_tdata,   // [31:0] window_min, [63:32] window_max
  input  wire        cfg_we,
  input  wire [8:0]  cfg_wdata,
  output int         errors,
  output int         pending
);
  import swmm_pkg::*;

  sample_t history [MAX_WINDOW];
  int      fill;
  addr_t   wpos;
  len_t    win_len;
  result_t expected_extrema [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  // store the sample, then scan the newest eff samples if the stream is long enough
  function automatic bit slide_window(input sample_t s, input bit restart, output result_t r);
    int      eff;
    addr_t   idx;
    sample_t lo;
    sample_t hi;
    r = '0;
    if (restart) begin
      fill = 0;
      wpos = '0;
    end
    history[wpos] = s;
    wpos = wpos + 1'b1;
    if (fill < MAX_WINDOW) fill++;
    if (win_len == '0) begin
      eff = 1;
    end else if (win_len > MAX_LEN) begin
      eff = MAX_WINDOW;
    end else begin
      eff = int'(win_len);
    end
    if (fill < eff) return 1'b0;
    lo = s;
    hi = s;
    for (int k = 1; k < eff; k++) begin
      idx = addr_t'(int'(wpos) - 1 - k);
      if (history[idx] < lo) lo = history[idx];
      if (history[idx] > hi) hi = history[idx];
    end
    r.win_min = lo;
    r.win_max = hi;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      fill    = 0;
      wpos    = '0;
      win_len = len_t'(1);
      expected_extrema.delete();
    end else begin
      if (cfg_we) win_len = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (slide_window(s_axis_tdata, s_axis_tuser, want)) expected_extrema.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_extrema.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: min %0d max %0d",
                                    got.win_min, got.win_max));
        end else begin
          want = expected_extrema.pop_front();
          if (got.win_min !== want.win_min) begin
            report_mismatch($sformatf("window_min %0d, expected %0d",
                                      got.win_min, want.win_min));
          end
          if (got.win_max !== want.win_max) begin
            report_mismatch($sformatf("window_max %0d, expected %0d",
                                      got.win_max, want.win_max));
          end
        end
      end
    end
    pending <= expected_extrema.size();
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top: clock, reset, sample stimulus, window length writes and the final verdict.
module testbench;
  import swmm_pkg::*;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;    // [31:0] sample
  logic        s_axis_tuser  = 1'b0;  // [0] new_stream
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [63:0] m_axis_tdata;          // [31:0] window_min, [63:32] window_max
  logic        cfg_we        = 1'b0;
  logic [8:0]  cfg_wdata     = '0;

  int   errors;
  int   pending;
  bit   gaps_on = 1'b1;
  int   phase;
  int   sent;
  int   eff;
  int   count;
  int   ns_permille;
  len_t len;
  len_t plan [8] = '{9'd2, 9'd5, 9'd511, 9'd16, 9'd0, 9'd256, 9'd33, 9'd1};

  sliding_window_min_max_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  window_extrema_check extrema_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= !gaps_on || ($urandom_range(99) >= 20);
  end

  function automatic sample_t next_sample();
    case ($urandom_range(7))
      0:       return sample_t'(32'h7FFF_FFFF);
      1:       return sample_t'(32'h8000_0000);
      2, 3:    return sample_t'($urandom_range(16)) - 8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input sample_t s, input bit restart);
    while (gaps_on && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // wait for every expected beat, then for the longest scan the block can run
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_window(input len_t v);
    s_axis_tvalid <= 1'b0;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window of one after reset
    push_sample(sample_t'(32'h7FFF_FFFF), 1'b1);
    push_sample(sample_t'(32'h8000_0000), 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    // zero length acts as one
    set_window(9'd0);
    push_sample(sample_t'(5), 1'b1);
    push_sample(sample_t'(-5), 1'b0);
    // restart before the window fills
    set_window(9'd3);
    push_sample(sample_t'(32'h8000_0000), 1'b1);
    push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    push_sample(sample_t'(1), 1'b1);
    push_sample(sample_t'(2), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    // shrink, then grow past the fill, mid-stream
    set_window(9'd2);
    push_sample(sample_t'(4), 1'b0);
    push_sample(sample_t'(-8), 1'b0);
    set_window(9'd9);
    push_sample(sample_t'(9), 1'b0);
    push_sample(sample_t'(10), 1'b0);
    push_sample(sample_t'(11), 1'b0);
    // oversized length saturates
    set_window(9'd511);
    push_sample(sample_t'(32'hFFFF_FFFF), 1'b1);
    push_sample(sample_t'(2), 1'b0);

    phase = 0;
    sent  = 0;
    while (sent < 1800) begin
      len = (phase < 8) ? plan[phase] : len_t'($urandom_range(1, 24));
      if (len == '0) begin
        eff = 1;
      end else if (len > MAX_LEN) begin
        eff = MAX_WINDOW;
      end else begin
        eff = int'(len);
      end
      count       = (eff >= 128) ? 300 : $urandom_range(80, 200);
      ns_permille = (eff <= 16) ? 30 : 3;
      set_window(len);
      gaps_on = (phase % 4 != 2);
      for (int i = 0; i < count; i++) begin
        push_sample(next_sample(),
                    (i == 0 && $urandom_range(1) == 1) || $urandom_range(999) < ns_permille);
      end
      sent += count;
      phase++;
    end
    gaps_on = 1'b1;
    s_axis_tvalid <= 1'b0;
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
